/* sv/tswd_pkg.sv */
`timescale 1ns / 1ps
// types and constants of the touch sensor stuck watchdog
// no dependencies
package tswd_pkg;

   localparam int DATA_W     = 16;
   localparam int MAX_BTN    = 4;
   localparam int BTN_IDX_W  = 2;
   localparam int SUM_W      = DATA_W + BTN_IDX_W;
   localparam int CSR_IDX_W  = 2;

   localparam logic [DATA_W-1:0] MIN_LEVEL_RESET   = 16'd12000;
   localparam logic [DATA_W-1:0] COUNT_LIMIT_RESET = 16'd5000;
   localparam logic [DATA_W-1:0] REF_LIMIT_RESET   = 16'd10000;
   localparam logic [DATA_W-1:0] IDLE_MAX          = 16'hFFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MIN_LEVEL   = 2'd0,
      REG_COUNT_LIMIT = 2'd1,
      REG_REF_LIMIT   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CAUSE_NONE  = 2'd0,
      CAUSE_LOW   = 2'd1,
      CAUSE_COUNT = 2'd2,
      CAUSE_REF   = 2'd3
   } cause_type;

   typedef struct packed {
      logic                 hit;
      logic [BTN_IDX_W-1:0] button;
   } pass_hit_type;

endpackage

/* sv/tswd_level_check.sv */
`timescale 1ns / 1ps
// low level check: per-scan sums of counts and references against min level
// depends on tswd_pkg
module tswd_level_check #(
   parameter int NUM_BUTTONS = 4
) (
   input  logic [NUM_BUTTONS-1:0][tswd_pkg::DATA_W-1:0] count_val,
   input  logic [NUM_BUTTONS-1:0][tswd_pkg::DATA_W-1:0] ref_val,
   input  logic [tswd_pkg::DATA_W-1:0]                  min_level,
   output logic                                         level_low
);

   logic [tswd_pkg::SUM_W-1:0] sum_cnt;
   logic [tswd_pkg::SUM_W-1:0] sum_ref;
   logic [tswd_pkg::SUM_W-1:0] threshold;

   always_comb begin
      sum_cnt = '0;
      sum_ref = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         sum_cnt = sum_cnt + tswd_pkg::SUM_W'(count_val[i]);
         sum_ref = sum_ref + tswd_pkg::SUM_W'(ref_val[i]);
      end
      threshold = tswd_pkg::SUM_W'(tswd_pkg::SUM_W'(min_level) *
                                   tswd_pkg::SUM_W'(NUM_BUTTONS));
      level_low = (sum_ref < threshold) || (sum_cnt < threshold);
   end

endmodule

/* sv/tswd_stuck_pass.sv */
`timescale 1ns / 1ps
// one stuck pass: per-button compare, idle counter update and first-hit search
// depends on tswd_pkg
module tswd_stuck_pass #(
   parameter int NUM_BUTTONS = 4
) (
   input  logic [NUM_BUTTONS-1:0][tswd_pkg::DATA_W-1:0] last_val,
   input  logic [NUM_BUTTONS-1:0][tswd_pkg::DATA_W-1:0] idle_cnt,
   input  logic [NUM_BUTTONS-1:0][tswd_pkg::DATA_W-1:0] now_val,
   input  logic [tswd_pkg::DATA_W-1:0]                  limit,
   output logic [NUM_BUTTONS-1:0][tswd_pkg::DATA_W-1:0] last_next,
   output logic [NUM_BUTTONS-1:0][tswd_pkg::DATA_W-1:0] idle_next,
   output tswd_pkg::pass_hit_type                       hit_info
);

   logic [NUM_BUTTONS-1:0] trig;

   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (last_val[i] != now_val[i]) begin
            last_next[i] = now_val[i];
            idle_next[i] = '0;
         end else begin
            last_next[i] = last_val[i];
            if (idle_cnt[i] == tswd_pkg::IDLE_MAX) begin
               idle_next[i] = idle_cnt[i];
            end else begin
               idle_next[i] = idle_cnt[i] + tswd_pkg::DATA_W'(1);
            end
         end
         trig[i] = (idle_next[i] >= limit);
      end
      hit_info.hit    = |trig;
      hit_info.button = '0;
      // lowest triggering button wins
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
         if (trig[i]) begin
            hit_info.button = tswd_pkg::BTN_IDX_W'(i);
         end
      end
   end

endmodule

/* sv/touch_sensor_stuck_watchdog_core.sv */
`timescale 1ns / 1ps
// Touch sensor stuck watchdog. One scan request is taken per clock cycle and its
// result is registered: the scan waits in the input register while the level
// check and the three stuck passes run into the result register, which also
// updates the per-button last values and idle counters. The rate is set by the
// compare and increment path per button. While a result waits on rsp_ready,
// one more request can enter the input register; the input stage stalls only
// when it is full and the result register is full and not taken. State clears
// at reset with no sweep. Depends on tswd_pkg, tswd_level_check, tswd_stuck_pass.
module touch_sensor_stuck_watchdog_core #(
   parameter int NUM_BUTTONS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tswd_pkg::DATA_W-1:0]       req_count_0,
   input  logic [tswd_pkg::DATA_W-1:0]       req_count_1,
   input  logic [tswd_pkg::DATA_W-1:0]       req_count_2,
   input  logic [tswd_pkg::DATA_W-1:0]       req_count_3,
   input  logic [tswd_pkg::DATA_W-1:0]       req_ref_0,
   input  logic [tswd_pkg::DATA_W-1:0]       req_ref_1,
   input  logic [tswd_pkg::DATA_W-1:0]       req_ref_2,
   input  logic [tswd_pkg::DATA_W-1:0]       req_ref_3,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_reinit,
   output logic [1:0]                        rsp_cause,
   output logic [tswd_pkg::BTN_IDX_W-1:0]    rsp_stuck_button,
   input  logic                              csr_we,
   input  logic [tswd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tswd_pkg::DATA_W-1:0]       csr_wdata
);

   typedef logic [NUM_BUTTONS-1:0][tswd_pkg::DATA_W-1:0] btn_vec_type;

   logic [tswd_pkg::MAX_BTN-1:0][tswd_pkg::DATA_W-1:0] req_cnt_all;
   logic [tswd_pkg::MAX_BTN-1:0][tswd_pkg::DATA_W-1:0] req_ref_all;

   logic [tswd_pkg::DATA_W-1:0] min_level_ff;
   logic [tswd_pkg::DATA_W-1:0] count_limit_ff;
   logic [tswd_pkg::DATA_W-1:0] ref_limit_ff;

   logic        in_valid_ff;
   btn_vec_type cnt_ff;
   btn_vec_type ref_ff;

   btn_vec_type last_cnt_ff, last_cnt_in;
   btn_vec_type cnt_idle_ff, cnt_idle_in;
   btn_vec_type last_ref_ff, last_ref_in;
   btn_vec_type ref_idle_ff, ref_idle_in;

   logic                           rsp_valid_ff;
   logic                           rsp_reinit_ff, rsp_reinit_in;
   tswd_pkg::cause_type            rsp_cause_ff, rsp_cause_in;
   logic [tswd_pkg::BTN_IDX_W-1:0] rsp_button_ff, rsp_button_in;

   logic level_low;
   logic advance;

   btn_vec_type pc_last, pc_idle;
   btn_vec_type pr_last, pr_idle;
   btn_vec_type pz_last, pz_idle;
   tswd_pkg::pass_hit_type cnt_hit, ref_hit, refz_hit, ref_sel;

   assign req_cnt_all = {req_count_3, req_count_2, req_count_1, req_count_0};
   assign req_ref_all = {req_ref_3, req_ref_2, req_ref_1, req_ref_0};

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_level_ff   <= tswd_pkg::MIN_LEVEL_RESET;
         count_limit_ff <= tswd_pkg::COUNT_LIMIT_RESET;
         ref_limit_ff   <= tswd_pkg::REF_LIMIT_RESET;
      end else if (csr_we) begin
         case (tswd_pkg::csr_index_type'(csr_index))
            tswd_pkg::REG_MIN_LEVEL:   min_level_ff   <= csr_wdata;
            tswd_pkg::REG_COUNT_LIMIT: count_limit_ff <= csr_wdata;
            tswd_pkg::REG_REF_LIMIT:   ref_limit_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cnt_ff <= req_cnt_all[NUM_BUTTONS-1:0];
         ref_ff <= req_ref_all[NUM_BUTTONS-1:0];
      end
   end

   tswd_level_check #(.NUM_BUTTONS(NUM_BUTTONS)) u_level (
      .count_val (cnt_ff),
      .ref_val   (ref_ff),
      .min_level (min_level_ff),
      .level_low (level_low)
   );

   tswd_stuck_pass #(.NUM_BUTTONS(NUM_BUTTONS)) u_cnt_pass (
      .last_val  (last_cnt_ff),
      .idle_cnt  (cnt_idle_ff),
      .now_val   (cnt_ff),
      .limit     (count_limit_ff),
      .last_next (pc_last),
      .idle_next (pc_idle),
      .hit_info  (cnt_hit)
   );

   tswd_stuck_pass #(.NUM_BUTTONS(NUM_BUTTONS)) u_ref_pass (
      .last_val  (last_ref_ff),
      .idle_cnt  (ref_idle_ff),
      .now_val   (ref_ff),
      .limit     (ref_limit_ff),
      .last_next (pr_last),
      .idle_next (pr_idle),
      .hit_info  (ref_hit)
   );

   // reference pass on cleared state, used after a count hit
   tswd_stuck_pass #(.NUM_BUTTONS(NUM_BUTTONS)) u_ref_zero_pass (
      .last_val  ('0),
      .idle_cnt  ('0),
      .now_val   (ref_ff),
      .limit     (ref_limit_ff),
      .last_next (pz_last),
      .idle_next (pz_idle),
      .hit_info  (refz_hit)
   );

   always_comb begin
      ref_sel = cnt_hit.hit ? refz_hit : ref_hit;

      last_cnt_in = pc_last;
      cnt_idle_in = pc_idle;
      last_ref_in = pr_last;
      ref_idle_in = pr_idle;
      if (level_low || ref_sel.hit) begin
         last_cnt_in = '0;
         cnt_idle_in = '0;
         last_ref_in = '0;
         ref_idle_in = '0;
      end else if (cnt_hit.hit) begin
         last_cnt_in = '0;
         cnt_idle_in = '0;
         last_ref_in = pz_last;
         ref_idle_in = pz_idle;
      end

      rsp_reinit_in = 1'b1;
      rsp_button_in = '0;
      if (level_low) begin
         rsp_cause_in = tswd_pkg::CAUSE_LOW;
      end else if (cnt_hit.hit) begin
         rsp_cause_in  = tswd_pkg::CAUSE_COUNT;
         rsp_button_in = cnt_hit.button;
      end else if (ref_sel.hit) begin
         rsp_cause_in  = tswd_pkg::CAUSE_REF;
         rsp_button_in = ref_sel.button;
      end else begin
         rsp_cause_in  = tswd_pkg::CAUSE_NONE;
         rsp_reinit_in = 1'b0;
      end
   end

   // per-button state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_cnt_ff <= '0;
         cnt_idle_ff <= '0;
         last_ref_ff <= '0;
         ref_idle_ff <= '0;
      end else if (advance) begin
         last_cnt_ff <= last_cnt_in;
         cnt_idle_ff <= cnt_idle_in;
         last_ref_ff <= last_ref_in;
         ref_idle_ff <= ref_idle_in;
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_reinit_ff <= rsp_reinit_in;
         rsp_cause_ff  <= rsp_cause_in;
         rsp_button_ff <= rsp_button_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reinit       = rsp_reinit_ff;
   assign rsp_cause        = 2'(rsp_cause_ff);
   assign rsp_stuck_button = rsp_button_ff;

   a_reinit_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reinit == (rsp_cause_ff != tswd_pkg::CAUSE_NONE)))
      else $error("reinit flag disagrees with cause");

   a_button_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_cause_ff == tswd_pkg::CAUSE_NONE ||
                    rsp_cause_ff == tswd_pkg::CAUSE_LOW)
      |-> (rsp_stuck_button == '0))
      else $error("stuck button set without a stuck cause");

   a_button_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_stuck_button) < NUM_BUTTONS))
      else $error("stuck button beyond active buttons");

   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      advance && (rsp_cause_in == tswd_pkg::CAUSE_LOW ||
                  rsp_cause_in == tswd_pkg::CAUSE_REF)
      |=> (last_cnt_ff == '0 && cnt_idle_ff == '0 &&
           last_ref_ff == '0 && ref_idle_ff == '0))
      else $error("state not cleared after re-init");

endmodule
